FILE: rtl/mstt_pkg.sv
// Shared types and constants for the multi-slot timer table.
// No dependencies; mstt_if.sv and multi_slot_timer_table.sv import this package.
package mstt_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int TIME_W    = 32;
	localparam int REP_W     = 8;
	localparam int TAG_W     = 16;
	localparam int SID_W     = 5;
	localparam int CNT_W     = 6;
	localparam int REQ_W     = 3;
	localparam int KIND_W    = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_START   = 3'd1,
		REQ_RESTART = 3'd2,
		REQ_CHANGE  = 3'd3,
		REQ_CANCEL  = 3'd4
	} req_code_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REPLY  = 2'd0,
		KIND_EXPIRY = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic {
		STAT_OK   = 1'b0,
		STAT_FAIL = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_CHK,
		ST_TICK_EVAL,
		ST_TICK_END,
		ST_START_SRCH,
		ST_MOD_RD,
		ST_MOD_WB,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]       start;
		logic [TIME_W-1:0]       limit;
		logic [REP_W-1:0]        repeats;
		logic [TAG_W-1:0]        tag;
	} slot_rec_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              status;
		logic [SID_W-1:0]  out_slot;
		logic [TAG_W-1:0]  out_handle;
		logic [CNT_W-1:0]  active_count;
		logic              last;
	} rsp_t;

endpackage

FILE: rtl/mstt_if.sv
// Valid/ready channel interfaces for timer table requests and results.
// Depends on mstt_pkg for field widths.
interface mstt_req_if import mstt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [SID_W-1:0]  slot_id;
	logic [TIME_W-1:0] timeout;
	logic signed [REP_W-1:0] repeat_count;
	logic [TAG_W-1:0]  handle;

	modport source (output valid, req_type, slot_id, timeout, repeat_count, handle,
		input ready);
	modport sink (input valid, req_type, slot_id, timeout, repeat_count, handle,
		output ready);
endinterface

interface mstt_rsp_if import mstt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              status;
	logic [SID_W-1:0]  out_slot;
	logic [TAG_W-1:0]  out_handle;
	logic [CNT_W-1:0]  active_count;
	logic              last;

	modport source (output valid, kind, status, out_slot, out_handle, active_count, last,
		input ready);
	modport sink (input valid, kind, status, out_slot, out_handle, active_count, last,
		output ready);
endinterface

FILE: rtl/mstt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mstt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/multi_slot_timer_table.sv
// Top level of the multi-slot timer table: sequencer, slot flags and result register.
// Depends on mstt_pkg, mstt_if.sv (channel interfaces) and mstt_ram (slot records).
//
// Usage: requests arrive as beats on req (tick, start, restart, change timeout,
// cancel); results leave as beats on rsp. Every request but a tick gives one
// reply beat with last set. A tick advances the time counter, then gives one
// expiry beat per slot that fires, in ascending slot order, and closes with an
// end-of-scan beat carrying last.
// Timing: one request at a time; req.ready is high only while the sequencer is
// idle, and returns on the edge that loads the closing beat. A tick walks the
// slot flags one free slot per cycle; each slot in use passes from ST_TICK_CHK
// to ST_TICK_EVAL to read its record from the slot RAM, and a firing slot waits
// there while the result register is full. A start walks the flags to the first
// free slot; restart and change timeout go through a read-modify-write of the
// record in ST_MOD_RD and ST_MOD_WB; cancel and failed restart or change
// requests reply from ST_REPLY.
// Reset clears the time counter, the in-use flags and the count; slot records
// need no clearing. A stalled receiver holds the result register and the
// sequencer waits at the next beat; one finished beat may wait while the next
// request is taken.
module multi_slot_timer_table import mstt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mstt_req_if.sink   req,
	mstt_rsp_if.source rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     idx_q;
	logic [AW-1:0]     idx_a;
	logic [TIME_W-1:0] now_q;
	logic [SLOTS-1:0]  used_q;
	logic [CNT_W-1:0]  count_q;
	logic [REQ_W-1:0]  type_q;
	logic [SID_W-1:0]  sid_q;
	logic [AW-1:0]     sid_a;
	logic [TIME_W-1:0] tmo_q;
	logic [REP_W-1:0]  rep_q;
	logic [TAG_W-1:0]  hnd_q;
	status_t           rep_status_q;
	logic [SID_W-1:0]  rep_slot_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              req_hit;
	logic              scan_done;
	logic              out_free;
	logic              fire;
	logic [TIME_W-1:0] elapsed;
	logic [REP_W-1:0]  rep_next;
	slot_rec_t         rd;
	logic [$bits(slot_rec_t)-1:0] rd_raw;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	slot_rec_t         ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic              emit;
	rsp_t              emit_pl;
	logic              used_we;
	logic [AW-1:0]     used_idx;
	logic              used_val;
	logic [CNT_W-1:0]  count_d;
	logic              idx_inc;

	mstt_ram #(
		.WIDTH ($bits(slot_rec_t)),
		.DEPTH (SLOTS)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_raw)
	);

	assign rd        = slot_rec_t'(rd_raw);
	assign idx_a     = idx_q[AW-1:0];
	assign sid_a     = AW'(sid_q);
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign scan_done = (idx_q == CW'(SLOTS));
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req_hit   = (int'(req.slot_id) < SLOTS) && used_q[AW'(req.slot_id)];
	assign elapsed   = now_q - rd.start;
	assign fire      = (elapsed >= rd.limit);
	assign rep_next  = (!rd.repeats[REP_W-1] && (rd.repeats != '0)) ?
		rd.repeats - REP_W'(1) : rd.repeats;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.req_type)
						REQ_TICK:    state_d = ST_TICK_CHK;
						REQ_START:   state_d = ST_START_SRCH;
						REQ_RESTART,
						REQ_CHANGE:  state_d = req_hit ? ST_MOD_RD : ST_REPLY;
						default:     state_d = ST_REPLY;
					endcase
				end
			end
			ST_TICK_CHK: begin
				if (scan_done) begin
					state_d = ST_TICK_END;
				end else if (used_q[idx_a]) begin
					state_d = ST_TICK_EVAL;
				end
			end
			ST_TICK_EVAL: begin
				if (!fire || out_free) begin
					state_d = ST_TICK_CHK;
				end
			end
			ST_TICK_END: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_START_SRCH: begin
				if ((scan_done || !used_q[idx_a]) && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_MOD_RD: state_d = ST_MOD_WB;
			ST_MOD_WB: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_a;
		ram_wdata = rd;
		ram_raddr = ((state_q == ST_MOD_RD) || (state_q == ST_MOD_WB)) ? sid_a : idx_a;
		emit      = 1'b0;
		emit_pl   = '{kind: KIND_REPLY, status: STAT_OK, out_slot: '0,
			out_handle: '0, active_count: count_q, last: 1'b1};
		used_we   = 1'b0;
		used_idx  = idx_a;
		used_val  = 1'b0;
		count_d   = count_q;
		idx_inc   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_CANCEL) && req_hit) begin
					used_we  = 1'b1;
					used_idx = AW'(req.slot_id);
					count_d  = count_q - CNT_W'(1);
				end
			end
			ST_TICK_CHK: begin
				idx_inc = !scan_done && !used_q[idx_a];
			end
			ST_TICK_EVAL: begin
				idx_inc = !fire || out_free;
				if (fire && out_free) begin
					ram_we            = 1'b1;
					ram_wdata.start   = now_q;
					ram_wdata.repeats = rep_next;
					if (rep_next == '0) begin
						used_we = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
					emit                 = 1'b1;
					emit_pl.kind         = KIND_EXPIRY;
					emit_pl.out_slot     = SID_W'(idx_a);
					emit_pl.out_handle   = rd.tag;
					emit_pl.active_count = count_d;
					emit_pl.last         = 1'b0;
				end
			end
			ST_TICK_END: begin
				emit         = out_free;
				emit_pl.kind = KIND_END;
			end
			ST_START_SRCH: begin
				if (scan_done) begin
					emit           = out_free;
					emit_pl.status = STAT_FAIL;
				end else if (!used_q[idx_a]) begin
					if (out_free) begin
						ram_we    = 1'b1;
						ram_wdata = '{start: now_q, limit: tmo_q, repeats: rep_q, tag: hnd_q};
						used_we   = 1'b1;
						used_val  = 1'b1;
						count_d   = count_q + CNT_W'(1);
						emit      = 1'b1;
						emit_pl.out_slot     = SID_W'(idx_a);
						emit_pl.active_count = count_d;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_MOD_WB: begin
				if (out_free) begin
					ram_we          = 1'b1;
					ram_waddr       = sid_a;
					ram_wdata.limit = tmo_q;
					if (type_q == REQ_RESTART) begin
						ram_wdata.start   = now_q;
						ram_wdata.repeats = rep_q;
					end
					emit             = 1'b1;
					emit_pl.out_slot = sid_q;
				end
			end
			ST_REPLY: begin
				emit             = out_free;
				emit_pl.status   = rep_status_q;
				emit_pl.out_slot = rep_slot_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			used_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (used_we) begin
				used_q[used_idx] <= used_val;
			end
			if (accept) begin
				idx_q <= '0;
				if (req.req_type == REQ_TICK) begin
					now_q <= now_q + TIME_W'(1);
				end
			end else if (idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_pl;
		end
		if (accept) begin
			type_q <= req.req_type;
			sid_q  <= req.slot_id;
			tmo_q  <= req.timeout;
			rep_q  <= req.repeat_count;
			hnd_q  <= req.handle;
			if ((req.req_type == REQ_RESTART) || (req.req_type == REQ_CHANGE) ||
				(req.req_type == REQ_CANCEL)) begin
				rep_status_q <= req_hit ? STAT_OK : STAT_FAIL;
				rep_slot_q   <= req.slot_id;
			end else begin
				rep_status_q <= STAT_FAIL;
				rep_slot_q   <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = rsp_q.kind;
	assign rsp.status       = rsp_q.status;
	assign rsp.out_slot     = rsp_q.out_slot;
	assign rsp.out_handle   = rsp_q.out_handle;
	assign rsp.active_count = rsp_q.active_count;
	assign rsp.last         = rsp_q.last;

	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) == $countones(used_q))
		else $error("slot count out of step with in-use flags");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!rsp_valid_q || rsp.ready))
		else $error("result overwritten while stalled");

	a_tick_advances_time: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_TICK)) |=> (now_q == $past(now_q) + TIME_W'(1)))
		else $error("tick did not advance the time counter");

endmodule
